[rtl/dqsd_pkg.sv]
// Package for the deque block: constants, codes, payload structs and sequencer states.
package dqsd_pkg;

    localparam int DEPTH_DEFAULT = 64;

    typedef enum logic [2:0] {
        FUNC_PUSH_FRONT = 3'd0,
        FUNC_PUSH_BACK  = 3'd1,
        FUNC_POP_FRONT  = 3'd2,
        FUNC_POP_BACK   = 3'd3,
        FUNC_COUNT      = 3'd4,
        FUNC_DELETE     = 3'd5,
        FUNC_CLEAR      = 3'd6,
        FUNC_DEDUPE     = 3'd7
    } func_t;

    localparam logic [1:0] ST_DONE = 2'd0;
    localparam logic [1:0] ST_NONE = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    typedef struct packed {
        logic [2:0]         func;
        logic signed [31:0] value_in;
    } in_item_t;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] value_out;
        logic [6:0]         match_count;
        logic [6:0]         size_now;
        logic               list_empty;
    } out_item_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_POP_RD,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_DD_RD_I,
        S_DD_RD_J,
        S_DD_CHK,
        S_DD_WR,
        S_RESULT
    } state_t;

endpackage

[rtl/deque_with_search_delete.sv]
// Top level of the bounded deque with count, delete-first, clear and dedupe.
// One transaction at a time; s_ready is high only while the sequencer is idle. Pushes, clear
// and a pop on an empty list go from idle straight to the result state; a pop on a non-empty
// list first passes through a memory read state. Count walks the held entries through the
// single memory read port, a read and a check state per entry; delete-first scans to the match
// the same way and then shifts later entries down, a read and a write state per entry; dedupe
// compares each entry against the kept prefix, a read and a check state per compare, so for a
// list of distinct values the number of compares grows with the square of its size.
// The memory read port and one 32-bit comparator set the pace. The result sits in an output
// register until taken, and a finished transaction waits there while that register is full.
module deque_with_search_delete #(
    parameter int DEPTH = dqsd_pkg::DEPTH_DEFAULT
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  dqsd_pkg::in_item_t   s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output dqsd_pkg::out_item_t  m_data
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

    logic [31:0] mem [DEPTH];
    logic [31:0] rd_data_reg;

    dqsd_pkg::state_t state_reg, state_next;
    logic [AW-1:0] front_reg, front_next;
    logic [CW-1:0] count_reg, count_next;
    dqsd_pkg::func_t func_reg, func_next;
    logic [31:0]   val_reg, val_next;
    logic [CW-1:0] i_reg, i_next, j_reg, j_next, k_reg, k_next;
    logic [CW-1:0] match_reg, match_next;
    logic [1:0]    status_reg, status_next;
    logic          m_valid_reg;
    dqsd_pkg::out_item_t m_data_reg;

    logic          rd_en, wr_en;
    logic [CW-1:0] rd_pos, wr_pos;
    logic [AW-1:0] rd_addr, wr_addr;
    logic [31:0]   wr_data;
    logic          s_fire;

    // Logical position to physical slot
    function automatic logic [AW-1:0] slot(input logic [AW-1:0] f, input logic [CW-1:0] p);
        logic [CW:0] s;
        s = (CW+1)'(f) + (CW+1)'(p);
        if (s >= (CW+1)'(DEPTH)) s = s - (CW+1)'(DEPTH);
        return s[AW-1:0];
    endfunction

    assign rd_addr = slot(front_reg, rd_pos);
    assign wr_addr = slot(front_reg, wr_pos);
    assign s_ready = (state_reg == dqsd_pkg::S_IDLE);
    assign s_fire  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) mem[wr_addr] <= wr_data;
        if (rd_en) rd_data_reg <= mem[rd_addr];
    end

    // Next-state logic
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            dqsd_pkg::S_IDLE: begin
                if (s_fire) begin
                    case (dqsd_pkg::func_t'(s_data.func))
                        dqsd_pkg::FUNC_POP_FRONT, dqsd_pkg::FUNC_POP_BACK:
                            state_next = (count_reg == '0) ? dqsd_pkg::S_RESULT
                                                            : dqsd_pkg::S_POP_RD;
                        dqsd_pkg::FUNC_COUNT, dqsd_pkg::FUNC_DELETE:
                            state_next = dqsd_pkg::S_SCAN_RD;
                        dqsd_pkg::FUNC_DEDUPE: state_next = dqsd_pkg::S_DD_RD_I;
                        default: state_next = dqsd_pkg::S_RESULT;
                    endcase
                end
            end
            dqsd_pkg::S_POP_RD: state_next = dqsd_pkg::S_RESULT;
            dqsd_pkg::S_SCAN_RD:
                state_next = (i_reg >= count_reg) ? dqsd_pkg::S_RESULT : dqsd_pkg::S_SCAN_CHK;
            dqsd_pkg::S_SCAN_CHK: begin
                if (func_reg == dqsd_pkg::FUNC_DELETE && rd_data_reg == val_reg)
                    state_next = dqsd_pkg::S_SHIFT_RD;
                else
                    state_next = dqsd_pkg::S_SCAN_RD;
            end
            dqsd_pkg::S_SHIFT_RD:
                state_next = (i_reg + 1'b1 < count_reg) ? dqsd_pkg::S_SHIFT_WR
                                                       : dqsd_pkg::S_RESULT;
            dqsd_pkg::S_SHIFT_WR: state_next = dqsd_pkg::S_SHIFT_RD;
            dqsd_pkg::S_DD_RD_I:
                state_next = (i_reg >= count_reg) ? dqsd_pkg::S_RESULT : dqsd_pkg::S_DD_RD_J;
            dqsd_pkg::S_DD_RD_J:
                state_next = (j_reg >= k_reg) ? dqsd_pkg::S_DD_WR : dqsd_pkg::S_DD_CHK;
            dqsd_pkg::S_DD_CHK:
                state_next = (rd_data_reg == val_reg) ? dqsd_pkg::S_DD_RD_I
                                                      : dqsd_pkg::S_DD_RD_J;
            dqsd_pkg::S_DD_WR: state_next = dqsd_pkg::S_DD_RD_I;
            dqsd_pkg::S_RESULT: if (!m_valid_reg || m_ready) state_next = dqsd_pkg::S_IDLE;
            default: state_next = dqsd_pkg::S_IDLE;
        endcase
    end

    // Datapath and memory control
    always_comb begin
        front_next  = front_reg;
        count_next  = count_reg;
        func_next   = func_reg;
        val_next    = val_reg;
        i_next      = i_reg;
        j_next      = j_reg;
        k_next      = k_reg;
        match_next  = match_reg;
        status_next = status_reg;
        rd_en = 1'b0;
        wr_en = 1'b0;
        rd_pos = i_reg;
        wr_pos = i_reg;
        wr_data = val_reg;
        case (state_reg)
            dqsd_pkg::S_IDLE: begin
                if (s_fire) begin
                    func_next   = dqsd_pkg::func_t'(s_data.func);
                    val_next    = s_data.value_in;
                    i_next      = '0;
                    j_next      = '0;
                    k_next      = '0;
                    match_next  = '0;
                    status_next = dqsd_pkg::ST_DONE;
                    case (dqsd_pkg::func_t'(s_data.func))
                        dqsd_pkg::FUNC_PUSH_FRONT: begin
                            if (count_reg >= DEPTH_C) status_next = dqsd_pkg::ST_FULL;
                            else begin
                                front_next = slot(front_reg, DEPTH_C - 1'b1);
                                wr_en   = 1'b1;
                                wr_pos  = DEPTH_C - 1'b1;
                                wr_data = s_data.value_in;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        dqsd_pkg::FUNC_PUSH_BACK: begin
                            if (count_reg >= DEPTH_C) status_next = dqsd_pkg::ST_FULL;
                            else begin
                                wr_en   = 1'b1;
                                wr_pos  = count_reg;
                                wr_data = s_data.value_in;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        dqsd_pkg::FUNC_POP_FRONT, dqsd_pkg::FUNC_POP_BACK: begin
                            if (count_reg == '0) status_next = dqsd_pkg::ST_NONE;
                        end
                        dqsd_pkg::FUNC_CLEAR: begin
                            count_next = '0;
                            front_next = '0;
                        end
                        default: ;
                    endcase
                end
            end
            dqsd_pkg::S_POP_RD: begin
                rd_en  = 1'b1;
                rd_pos = (func_reg == dqsd_pkg::FUNC_POP_FRONT) ? '0 : count_reg - 1'b1;
                if (func_reg == dqsd_pkg::FUNC_POP_FRONT)
                    front_next = slot(front_reg, CW'(1));
                count_next = count_reg - 1'b1;
            end
            dqsd_pkg::S_SCAN_RD: begin
                rd_en  = 1'b1;
                rd_pos = i_reg;
                if (i_reg >= count_reg && func_reg == dqsd_pkg::FUNC_DELETE)
                    status_next = dqsd_pkg::ST_NONE;
            end
            dqsd_pkg::S_SCAN_CHK: begin
                if (rd_data_reg == val_reg) begin
                    if (func_reg == dqsd_pkg::FUNC_COUNT) begin
                        match_next = match_reg + 1'b1;
                        i_next = i_reg + 1'b1;
                    end
                end else begin
                    i_next = i_reg + 1'b1;
                end
            end
            dqsd_pkg::S_SHIFT_RD: begin
                rd_en  = 1'b1;
                rd_pos = i_reg + 1'b1;
                if (!(i_reg + 1'b1 < count_reg)) count_next = count_reg - 1'b1;
            end
            dqsd_pkg::S_SHIFT_WR: begin
                wr_en   = 1'b1;
                wr_pos  = i_reg;
                wr_data = rd_data_reg;
                i_next  = i_reg + 1'b1;
            end
            dqsd_pkg::S_DD_RD_I: begin
                rd_en  = 1'b1;
                rd_pos = i_reg;
                j_next = '0;
                if (i_reg >= count_reg) count_next = k_reg;
            end
            dqsd_pkg::S_DD_RD_J: begin
                // First cycle after RD_I: capture the candidate
                if (j_reg == '0) val_next = rd_data_reg;
                rd_en  = 1'b1;
                rd_pos = j_reg;
            end
            dqsd_pkg::S_DD_CHK: begin
                j_next = j_reg + 1'b1;
                if (rd_data_reg == val_reg) i_next = i_reg + 1'b1;
            end
            dqsd_pkg::S_DD_WR: begin
                wr_en   = 1'b1;
                wr_pos  = k_reg;
                wr_data = (k_reg == '0) ? rd_data_reg : val_reg;
                k_next  = k_reg + 1'b1;
                i_next  = i_reg + 1'b1;
            end
            default: ;
        endcase
    end

    // Control and payload registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= dqsd_pkg::S_IDLE;
            front_reg   <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            front_reg <= front_next;
            count_reg <= count_next;
            if (m_valid_reg && m_ready) m_valid_reg <= 1'b0;
            if (state_reg == dqsd_pkg::S_RESULT && (!m_valid_reg || m_ready))
                m_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        func_reg   <= func_next;
        val_reg    <= val_next;
        i_reg      <= i_next;
        j_reg      <= j_next;
        k_reg      <= k_next;
        match_reg  <= match_next;
        status_reg <= status_next;
        if (state_reg == dqsd_pkg::S_RESULT && (!m_valid_reg || m_ready)) begin
            m_data_reg.status      <= status_reg;
            m_data_reg.value_out   <= ((func_reg == dqsd_pkg::FUNC_POP_FRONT
                                        || func_reg == dqsd_pkg::FUNC_POP_BACK)
                                       && status_reg == dqsd_pkg::ST_DONE) ? rd_data_reg : '0;
            m_data_reg.match_count <= 7'(match_reg);
            m_data_reg.size_now    <= 7'(count_reg);
            m_data_reg.list_empty  <= (count_reg == '0);
        end
    end

`ifndef ASSERT_OFF
    // Fill level never exceeds the store depth
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= DEPTH_C) else $error("entry count above depth");
    // Input is only taken while the sequencer is idle
    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> (state_reg == dqsd_pkg::S_IDLE)) else $error("ready outside idle");
    // An accepted transaction leaves idle on the next edge
    a_leave_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |=> (state_reg != dqsd_pkg::S_IDLE)) else $error("accept did not start work");
    // Dedupe keeps no more entries than it has scanned
    a_dd_keep: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == dqsd_pkg::S_DD_RD_I) |-> (k_reg <= i_reg)) else $error("dedupe overrun");
`endif

endmodule

[test/tb_top.sv]
// Testbench for the bounded deque: directed table, then random traffic, checked by a predictor.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = dqsd_pkg::DEPTH_DEFAULT;
    localparam int N_RANDOM = 2000;
    localparam int N_ROWS = 15;

    logic                aclk;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    dqsd_pkg::in_item_t  s_data;
    logic                m_valid;
    logic                m_ready;
    dqsd_pkg::out_item_t m_data;

    deque_with_search_delete #(.DEPTH(DEPTH)) u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    // predictor state
    logic [31:0] dq_mem [DEPTH];
    int          dq_front;
    int          dq_count;

    dqsd_pkg::out_item_t pending_results[$];
    int          errors;
    int          n_sent;
    int          n_checked;
    int          n_full;
    int          n_empty_pop;
    bit          input_done;

    // directed rows: operation, value, whether a result is typed in, and that result
    typedef struct {
        dqsd_pkg::func_t     op;
        logic [31:0]         val;
        bit                  fixed;
        dqsd_pkg::out_item_t res;
    } stim_row_t;

    function automatic dqsd_pkg::out_item_t mk_res(logic [1:0] st, logic [31:0] v,
                                                   int mc, int sz);
        dqsd_pkg::out_item_t r;
        r.status      = st;
        r.value_out   = v;
        r.match_count = mc[6:0];
        r.size_now    = sz[6:0];
        r.list_empty  = (sz == 0);
        return r;
    endfunction

    function automatic int slot(int pos);
        return (dq_front + pos) % DEPTH;
    endfunction

    // apply one operation to the predicted deque and return its result
    function automatic dqsd_pkg::out_item_t deque_apply(dqsd_pkg::func_t op, logic [31:0] v);
        logic [1:0]  st;
        logic [31:0] popped;
        int          n_hits;
        int          i, j, k;
        bit          seen;
        logic [31:0] x;
        st = dqsd_pkg::ST_DONE;
        popped = '0;
        n_hits = 0;
        case (op)
            dqsd_pkg::FUNC_PUSH_FRONT: begin
                if (dq_count >= DEPTH) st = dqsd_pkg::ST_FULL;
                else begin
                    dq_front = (dq_front + DEPTH - 1) % DEPTH;
                    dq_mem[dq_front] = v;
                    dq_count++;
                end
            end
            dqsd_pkg::FUNC_PUSH_BACK: begin
                if (dq_count >= DEPTH) st = dqsd_pkg::ST_FULL;
                else begin
                    dq_mem[slot(dq_count)] = v;
                    dq_count++;
                end
            end
            dqsd_pkg::FUNC_POP_FRONT: begin
                if (dq_count == 0) st = dqsd_pkg::ST_NONE;
                else begin
                    popped = dq_mem[dq_front];
                    dq_front = (dq_front + 1) % DEPTH;
                    dq_count--;
                end
            end
            dqsd_pkg::FUNC_POP_BACK: begin
                if (dq_count == 0) st = dqsd_pkg::ST_NONE;
                else begin
                    popped = dq_mem[slot(dq_count - 1)];
                    dq_count--;
                end
            end
            dqsd_pkg::FUNC_COUNT: begin
                for (i = 0; i < dq_count; i++)
                    if (dq_mem[slot(i)] == v) n_hits++;
            end
            dqsd_pkg::FUNC_DELETE: begin
                for (i = 0; i < dq_count; i++)
                    if (dq_mem[slot(i)] == v) break;
                if (i >= dq_count) st = dqsd_pkg::ST_NONE;
                else begin
                    for (j = i; j + 1 < dq_count; j++)
                        dq_mem[slot(j)] = dq_mem[slot(j + 1)];
                    dq_count--;
                end
            end
            dqsd_pkg::FUNC_CLEAR: begin
                dq_count = 0;
                dq_front = 0;
            end
            default: begin
                // keep first occurrences, compacting toward the front
                k = 0;
                for (i = 0; i < dq_count; i++) begin
                    x = dq_mem[slot(i)];
                    seen = 0;
                    for (j = 0; j < k; j++)
                        if (dq_mem[slot(j)] == x) seen = 1;
                    if (!seen) begin
                        dq_mem[slot(k)] = x;
                        k++;
                    end
                end
                dq_count = k;
            end
        endcase
        if (st == dqsd_pkg::ST_FULL) n_full++;
        if (st == dqsd_pkg::ST_NONE && (op == dqsd_pkg::FUNC_POP_FRONT
                                        || op == dqsd_pkg::FUNC_POP_BACK))
            n_empty_pop++;
        return mk_res(st, popped, n_hits, dq_count);
    endfunction

    // clock
    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    // send one transaction after a random gap; the table may supply a fixed result
    task automatic send_item(dqsd_pkg::func_t op, logic [31:0] v, bit fixed,
                             dqsd_pkg::out_item_t fixed_res);
        dqsd_pkg::out_item_t predicted;
        int gap;
        gap = $urandom_range(0, 5);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        predicted = deque_apply(op, v);
        if (fixed && predicted !== fixed_res) begin
            $display("%0t: table row disagrees with predictor: exp %p got %p",
                     $time, fixed_res, predicted);
            errors++;
        end
        pending_results.insert(pending_results.size(), fixed ? fixed_res : predicted);
        s_data.func     <= op;
        s_data.value_in <= v;
        s_valid         <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        n_sent++;
        @(negedge aclk);
    endtask

    // random value: small pool for repeats, sometimes fully random or extreme
    function automatic logic [31:0] rand_value();
        case ($urandom_range(0, 9))
            0:       return $urandom();
            1:       return 32'h8000_0000;
            2:       return 32'h7FFF_FFFF;
            3:       return 32'hFFFF_FFFF;
            default: return $urandom_range(0, 7);
        endcase
    endfunction

    // random operation, weighted by a push bias so the store swings between empty and full
    function automatic dqsd_pkg::func_t rand_op(int bias_fill);
        int r;
        r = $urandom_range(0, 99);
        if (r < bias_fill)
            return ($urandom_range(0, 1)) ? dqsd_pkg::FUNC_PUSH_BACK : dqsd_pkg::FUNC_PUSH_FRONT;
        r = $urandom_range(0, 99);
        if (r < 30)
            return ($urandom_range(0, 1)) ? dqsd_pkg::FUNC_POP_FRONT : dqsd_pkg::FUNC_POP_BACK;
        if (r < 55) return dqsd_pkg::FUNC_COUNT;
        if (r < 85) return dqsd_pkg::FUNC_DELETE;
        if (r < 88) return dqsd_pkg::FUNC_CLEAR;
        return dqsd_pkg::FUNC_DEDUPE;
    endfunction

    // stimulus
    initial begin
        stim_row_t       rows [N_ROWS];
        int              phase_fill;
        dqsd_pkg::func_t op;
        s_valid  = 0;
        s_data   = '0;
        aresetn  = 0;
        errors   = 0;
        n_sent   = 0;
        n_full   = 0;
        n_empty_pop = 0;
        input_done = 0;
        dq_front = 0;
        dq_count = 0;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1;

        rows[0]  = '{dqsd_pkg::FUNC_POP_FRONT,  32'd0, 1'b1,
                     mk_res(dqsd_pkg::ST_NONE, '0, 0, 0)};
        rows[1]  = '{dqsd_pkg::FUNC_POP_BACK,   32'd0, 1'b1,
                     mk_res(dqsd_pkg::ST_NONE, '0, 0, 0)};
        rows[2]  = '{dqsd_pkg::FUNC_DELETE,     32'd5, 1'b1,
                     mk_res(dqsd_pkg::ST_NONE, '0, 0, 0)};
        rows[3]  = '{dqsd_pkg::FUNC_COUNT,      32'd5, 1'b1,
                     mk_res(dqsd_pkg::ST_DONE, '0, 0, 0)};
        rows[4]  = '{dqsd_pkg::FUNC_DEDUPE,     32'd0, 1'b1,
                     mk_res(dqsd_pkg::ST_DONE, '0, 0, 0)};
        rows[5]  = '{dqsd_pkg::FUNC_PUSH_BACK,  32'h8000_0000, 1'b1,
                     mk_res(dqsd_pkg::ST_DONE, '0, 0, 1)};
        rows[6]  = '{dqsd_pkg::FUNC_POP_BACK,   32'd0, 1'b1,
                     mk_res(dqsd_pkg::ST_DONE, 32'h8000_0000, 0, 0)};
        rows[7]  = '{dqsd_pkg::FUNC_PUSH_FRONT, 32'h7FFF_FFFF, 1'b1,
                     mk_res(dqsd_pkg::ST_DONE, '0, 0, 1)};
        rows[8]  = '{dqsd_pkg::FUNC_PUSH_FRONT, 32'hFFFF_FFFF, 1'b1,
                     mk_res(dqsd_pkg::ST_DONE, '0, 0, 2)};
        rows[9]  = '{dqsd_pkg::FUNC_PUSH_BACK,  32'hFFFF_FFFF, 1'b1,
                     mk_res(dqsd_pkg::ST_DONE, '0, 0, 3)};
        rows[10] = '{dqsd_pkg::FUNC_COUNT,      32'hFFFF_FFFF, 1'b1,
                     mk_res(dqsd_pkg::ST_DONE, '0, 2, 3)};
        rows[11] = '{dqsd_pkg::FUNC_DEDUPE,     32'd0, 1'b0, '0};
        rows[12] = '{dqsd_pkg::FUNC_DELETE,     32'h7FFF_FFFF, 1'b0, '0};
        rows[13] = '{dqsd_pkg::FUNC_POP_FRONT,  32'd0, 1'b0, '0};
        rows[14] = '{dqsd_pkg::FUNC_CLEAR,      32'd0, 1'b1,
                     mk_res(dqsd_pkg::ST_DONE, '0, 0, 0)};
        foreach (rows[i]) send_item(rows[i].op, rows[i].val, rows[i].fixed, rows[i].res);

        // fill past full, with repeats, then count, delete from the middle and dedupe
        for (int i = 0; i < DEPTH + 2; i++)
            send_item((i % 2) ? dqsd_pkg::FUNC_PUSH_FRONT : dqsd_pkg::FUNC_PUSH_BACK,
                      i % 5, 0, '0);
        send_item(dqsd_pkg::FUNC_COUNT, 32'd3, 0, '0);
        send_item(dqsd_pkg::FUNC_DELETE, 32'd4, 0, '0);
        send_item(dqsd_pkg::FUNC_DEDUPE, 32'd0, 0, '0);

        // random part in phases of differing fill bias
        for (int n = 0; n < N_RANDOM; n++) begin
            if (n % 200 == 0) phase_fill = $urandom_range(10, 80);
            op = rand_op(phase_fill);
            send_item(op, rand_value(), 0, '0);
        end
        s_valid <= 1'b0;
        input_done = 1;
    end

    // result side: random stalls, compare against the oldest expectation
    initial begin
        dqsd_pkg::out_item_t exp_res;
        int stall;
        m_ready = 0;
        n_checked = 0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            stall = $urandom_range(0, 5);
            if ($urandom_range(0, 3) == 0) stall = 0;
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result %p", $time, m_data);
                errors++;
            end else begin
                exp_res = pending_results[0];
                pending_results.delete(0);
                if (m_data.status !== exp_res.status ||
                    m_data.value_out !== exp_res.value_out ||
                    m_data.match_count !== exp_res.match_count ||
                    m_data.size_now !== exp_res.size_now ||
                    m_data.list_empty !== exp_res.list_empty) begin
                    $display("%0t: mismatch expected %p actual %p", $time, exp_res, m_data);
                    errors++;
                end
            end
            n_checked++;
        end
    end

    // end of run
    initial begin
        wait (input_done);
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
        $display("Sent %0d transactions, checked %0d results", n_sent, n_checked);
        $display("Full-push drops: %0d, pops on empty: %0d", n_full, n_empty_pop);
        if (errors == 0 && n_checked == n_sent)
            $display("deque_with_search_delete test passed");
        else
            $display("deque_with_search_delete test failed");
        $finish;
    end

    // watchdog
    initial begin
        #200ms;
        $display("deque_with_search_delete test failed");
        $finish;
    end
endmodule
